### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion checked on every rising edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/reb_pkg.sv
`timescale 1ns / 1ps

package reb_pkg;

  localparam int unsigned LimitW = 16;
  localparam logic [LimitW-1:0] LONG_PRESS_RESET = LimitW'(1000);
  localparam logic [LimitW-1:0] ELAPSED_MAX = '1;

  localparam int unsigned InW = 8;
  localparam int unsigned OutW = 8;

  // Input item, latch_level in bit 0.
  typedef struct packed {
    logic take_extended;
    logic take_brief;
    logic take_right;
    logic take_left;
    logic ms_tick;
    logic button_level;
    logic data_level;
    logic latch_level;
  } in_item_t;

  // Result item, left_taken in bit 0.
  typedef struct packed {
    logic [3:0] events_pending;
    logic       extended_taken;
    logic       brief_taken;
    logic       right_taken;
    logic       left_taken;
  } result_t;

endpackage

### sv/rotary_encoder_button_decoder_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Rotary encoder and push button decoder.
// Input stream (s_axis_*): one item per transfer carrying the sampled latch,
// data and button pin levels, a millisecond tick and four take requests.
// Output stream (m_axis_*): exactly one result per input item, in order,
// with the four take answers and the pending-event mask after the item.
// Configuration (cfg_*): writes the 16-bit long-press limit in milliseconds;
// it is always ready and should be written only while the block is idle.
// A result is registered, in the skid register while the receiver stalls.
// Throughput is one item per cycle while s_axis_tready is high; the whole
// decode is a single pass of logic from input transfer to result register.
// A two-entry output buffer (result register plus skid register) lets the
// block keep accepting while the receiver stalls; s_axis_tready drops only
// once both entries are full.
// Reset (rst, synchronous) clears all flags, the hold counter and the
// output buffer, and sets the limit to 1000 ms. The first item after reset
// only captures the pin levels.
module rotary_encoder_button_decoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [0] latch_level, [1] data_level, [2] button_level, [3] ms_tick,
  // [4] take_left, [5] take_right, [6] take_brief, [7] take_extended
  input  logic [reb_pkg::InW-1:0]    s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] left_taken, [1] right_taken, [2] brief_taken, [3] extended_taken,
  // [7:4] events_pending
  output logic [reb_pkg::OutW-1:0]   m_axis_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [reb_pkg::LimitW-1:0] cfg_data
);

  logic [reb_pkg::LimitW-1:0] long_press_ms;
  logic                       primed;
  logic                       latch_prev;
  logic                       button_pressed_prev;
  logic                       left_pending;
  logic                       right_pending;
  logic                       brief_pending;
  logic                       hold_active;
  logic [reb_pkg::LimitW-1:0] hold_elapsed;

  logic                       primed_next;
  logic                       left_pending_next;
  logic                       right_pending_next;
  logic                       brief_pending_next;
  logic                       hold_active_next;
  logic [reb_pkg::LimitW-1:0] hold_elapsed_next;

  reb_pkg::in_item_t in_item;
  reb_pkg::result_t  result;
  reb_pkg::result_t  out_data;
  reb_pkg::result_t  skid_data;
  logic              out_valid;
  logic              skid_valid;
  logic              in_xfer;
  logic              out_xfer;
  logic              pressed;
  logic              ext_ready;

  assign in_item = reb_pkg::in_item_t'(s_axis_tdata);
  assign pressed = ~in_item.button_level;

  assign s_axis_tready = ~skid_valid;
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_xfer      = out_valid & m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cfg_ready     = 1'b1;

  always_comb begin
    primed_next        = 1'b1;
    left_pending_next  = left_pending;
    right_pending_next = right_pending;
    brief_pending_next = brief_pending;
    hold_active_next   = hold_active;
    hold_elapsed_next  = hold_elapsed;
    result             = '0;

    // The tick is applied before the pins are looked at.
    if (in_item.ms_tick && hold_active && (hold_elapsed != reb_pkg::ELAPSED_MAX)) begin
      hold_elapsed_next = hold_elapsed + reb_pkg::LimitW'(1);
    end

    if (primed) begin
      if (in_item.latch_level != latch_prev) begin
        if (in_item.latch_level != in_item.data_level) begin
          right_pending_next = 1'b1;
        end else begin
          left_pending_next = 1'b1;
        end
      end
      if (pressed && !button_pressed_prev) begin
        hold_active_next  = 1'b1;
        hold_elapsed_next = '0;
      end else if (!pressed && button_pressed_prev) begin
        // A release past the limit leaves the hold for the extended take.
        if (hold_active && (hold_elapsed_next < long_press_ms)) begin
          hold_active_next   = 1'b0;
          brief_pending_next = 1'b1;
        end
      end
    end

    result.left_taken = in_item.take_left & left_pending_next;
    if (result.left_taken) begin
      left_pending_next = 1'b0;
    end
    result.right_taken = in_item.take_right & right_pending_next;
    if (result.right_taken) begin
      right_pending_next = 1'b0;
    end
    result.brief_taken = in_item.take_brief & brief_pending_next;
    if (result.brief_taken) begin
      brief_pending_next = 1'b0;
    end
    ext_ready = hold_active_next & (hold_elapsed_next >= long_press_ms);
    result.extended_taken = in_item.take_extended & ext_ready;
    if (result.extended_taken) begin
      hold_active_next = 1'b0;
    end

    result.events_pending = {hold_active_next & (hold_elapsed_next >= long_press_ms),
                             brief_pending_next, right_pending_next, left_pending_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms       <= reb_pkg::LONG_PRESS_RESET;
      primed              <= 1'b0;
      latch_prev          <= 1'b0;
      button_pressed_prev <= 1'b0;
      left_pending        <= 1'b0;
      right_pending       <= 1'b0;
      brief_pending       <= 1'b0;
      hold_active         <= 1'b0;
      hold_elapsed        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        long_press_ms <= cfg_data;
      end
      if (in_xfer) begin
        primed              <= primed_next;
        latch_prev          <= in_item.latch_level;
        button_pressed_prev <= pressed;
        left_pending        <= left_pending_next;
        right_pending       <= right_pending_next;
        brief_pending       <= brief_pending_next;
        hold_active         <= hold_active_next;
        hold_elapsed        <= hold_elapsed_next;
      end
    end
  end

  // Output buffer: the skid entry fills only when the result register is
  // held by a stalled receiver, and input stops while it is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_data <= skid_data;
      end
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

  `ASSERT_ALWAYS(a_skid_implies_out, skid_valid |-> out_valid,
                 "skid entry full while result register empty")
  `ASSERT_CLK(a_result_follows_input, in_xfer |=> m_axis_tvalid,
              "no result after an input transfer")
  `ASSERT_CLK(a_ext_taken_clears_ready,
              m_axis_tvalid |-> !(out_data.extended_taken && out_data.events_pending[3]),
              "extended push still pending after it was taken")
  `ASSERT_CLK(a_stall_holds_skid, (skid_valid && !m_axis_tready) |=> skid_valid,
              "skid entry lost while receiver stalled")

endmodule
